[src/rft_pkg.sv]
`default_nettype none

package rft_pkg;

    localparam int CNT_W    = 7;
    localparam int RAIL_W   = 7;
    localparam int STRIDE_W = 8;
    localparam int POS_W    = 9;

    localparam logic [RAIL_W-1:0] RAILS_RESET = RAIL_W'(3);

    typedef logic [RAIL_W-1:0] rails_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic       truncated;
    } out_item_t;

    // One command from the front to the back: an optional store of a byte
    // into the message buffer, and an optional start of the zigzag emit.
    typedef struct packed {
        logic             store;
        logic             emit;
        logic [7:0]       data;
        logic [CNT_W-1:0] addr;
        logic [CNT_W-1:0] len;
        logic             trunc;
        rails_t           rails;
    } cmd_t;

endpackage

`default_nettype wire

[src/rft_front.sv]
`default_nettype none

module rft_front #(
    parameter int BUFFER_DEPTH = 64
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire rft_pkg::rails_t  cfg_wdata,
    input  wire logic             push,
    output logic                  full,
    input  wire rft_pkg::in_item_t in_item,
    output logic                  cmd_push,
    output rft_pkg::cmd_t         cmd,
    input  wire logic             cmd_full
);
    import rft_pkg::*;

    logic [CNT_W-1:0] count_reg, count_next;
    logic             overflow_reg, overflow_next;
    rails_t           rails_reg;
    logic             accept;
    logic             stored;

    assign full   = cmd_full;
    assign accept = push && !cmd_full;
    assign stored = count_reg < CNT_W'(BUFFER_DEPTH);

    assign cmd_push   = accept && (stored || in_item.in_last);
    assign cmd.store  = stored;
    assign cmd.emit   = in_item.in_last;
    assign cmd.data   = in_item.in_byte;
    assign cmd.addr   = count_reg;
    assign cmd.len    = count_reg + CNT_W'(stored);
    assign cmd.trunc  = overflow_reg || !stored;
    assign cmd.rails  = rails_reg;

    always_comb
    begin
        count_next    = count_reg;
        overflow_next = overflow_reg;
        if (accept)
        begin
            if (in_item.in_last)
            begin
                count_next    = '0;
                overflow_next = 1'b0;
            end
            else if (stored)
            begin
                count_next = count_reg + CNT_W'(1);
            end
            else
            begin
                overflow_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            rails_reg    <= RAILS_RESET;
        end
        else
        begin
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
            if (cfg_we)
            begin
                rails_reg <= cfg_wdata;
            end
        end
    end

endmodule

`default_nettype wire

[src/rft_cmd_fifo.sv]
`default_nettype none

module rft_cmd_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire rft_pkg::cmd_t wr_data,
    output logic               full,
    input  wire logic          rd_en,
    output rft_pkg::cmd_t      rd_data,
    output logic               empty
);
    import rft_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   fill_reg;
    logic             do_wr, do_rd;

    assign full    = fill_reg == (PTR_W+1)'(DEPTH);
    assign empty   = fill_reg == '0;
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (do_wr && !do_rd)
            begin
                fill_reg <= fill_reg + (PTR_W+1)'(1);
            end
            else if (do_rd && !do_wr)
            begin
                fill_reg <= fill_reg - (PTR_W+1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

[src/rft_emit.sv]
`default_nettype none

module rft_emit #(
    parameter int BUFFER_DEPTH = 64
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire rft_pkg::cmd_t cmd,
    input  wire logic          cmd_empty,
    output logic               cmd_pop,
    output logic               empty,
    input  wire logic          pop,
    output rft_pkg::out_item_t out_item
);
    import rft_pkg::*;

    localparam int AW = $clog2(BUFFER_DEPTH);

    typedef enum logic [1:0] {B_IDLE, B_READ, B_HOLD} state_t;

    logic [7:0]          msg_mem [BUFFER_DEPTH];
    logic [7:0]          rd_data_reg;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    n_reg, n_next;
    rails_t              rails_reg, rails_next;
    logic [STRIDE_W-1:0] period_reg, period_next;
    logic                trunc_reg, trunc_next;
    rails_t              r_reg, r_next;
    logic [POS_W-1:0]    j_reg, j_next;
    logic                phase_reg, phase_next;
    logic                last_reg, last_next;
    logic                out_valid_reg, out_valid_next;
    out_item_t           out_item_reg, out_item_next;

    logic                edge_rail;
    rails_t              rails_m1;
    logic [STRIDE_W-1:0] stride;
    logic [POS_W-1:0]    j_step;
    logic [RAIL_W:0]     rail_after;
    logic                rail_done;
    logic                msg_done;
    logic                load;
    logic                pass;

    assign rails_m1   = rails_reg - RAIL_W'(1);
    assign edge_rail  = (r_reg == '0) || (r_reg == rails_m1);
    assign stride     = edge_rail ? period_reg
                      : (phase_reg ? {r_reg, 1'b0} : {rails_m1 - r_reg, 1'b0});
    assign j_step     = j_reg + POS_W'(stride);
    assign rail_after = {1'b0, r_reg} + (RAIL_W+1)'(1);
    assign rail_done  = j_step >= POS_W'(n_reg);
    assign msg_done   = rail_done && ((rail_after >= {1'b0, rails_reg})
                                   || (rail_after >= (RAIL_W+1)'(n_reg)));
    assign load       = (state_reg == B_HOLD) && (!out_valid_reg || pop);
    assign cmd_pop    = (state_reg == B_IDLE) && !cmd_empty;
    assign pass       = (cmd.rails <= RAIL_W'(1)) || (cmd.len <= CNT_W'(1));

    assign empty    = !out_valid_reg;
    assign out_item = out_item_reg;

    always_ff @(posedge clk)
    begin
        if (cmd_pop && cmd.store)
        begin
            msg_mem[cmd.addr[AW-1:0]] <= cmd.data;
        end
        if (state_reg == B_READ)
        begin
            rd_data_reg <= msg_mem[j_reg[AW-1:0]];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        rails_next     = rails_reg;
        period_next    = period_reg;
        trunc_next     = trunc_reg;
        r_next         = r_reg;
        j_next         = j_reg;
        phase_next     = phase_reg;
        last_next      = last_reg;
        out_item_next  = out_item_reg;
        out_valid_next = out_valid_reg && !pop;
        case (state_reg)
            B_IDLE:
            begin
                if (cmd_pop && cmd.emit)
                begin
                    n_next      = cmd.len;
                    trunc_next  = cmd.trunc;
                    rails_next  = pass ? RAIL_W'(1) : cmd.rails;
                    period_next = pass ? STRIDE_W'(1)
                                       : {cmd.rails - RAIL_W'(1), 1'b0};
                    r_next      = '0;
                    j_next      = '0;
                    phase_next  = 1'b0;
                    state_next  = B_READ;
                end
            end
            B_READ:
            begin
                last_next = msg_done;
                if (rail_done)
                begin
                    r_next     = rail_after[RAIL_W-1:0];
                    j_next     = POS_W'(rail_after);
                    phase_next = 1'b0;
                end
                else
                begin
                    j_next     = j_step;
                    phase_next = !phase_reg;
                end
                state_next = B_HOLD;
            end
            B_HOLD:
            begin
                if (load)
                begin
                    out_item_next.out_byte  = rd_data_reg;
                    out_item_next.out_last  = last_reg;
                    out_item_next.truncated = trunc_reg;
                    out_valid_next          = 1'b1;
                    state_next              = last_reg ? B_IDLE : B_READ;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            n_reg         <= '0;
            rails_reg     <= '0;
            period_reg    <= '0;
            trunc_reg     <= 1'b0;
            r_reg         <= '0;
            j_reg         <= '0;
            phase_reg     <= 1'b0;
            last_reg      <= 1'b0;
            out_item_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            n_reg         <= n_next;
            rails_reg     <= rails_next;
            period_reg    <= period_next;
            trunc_reg     <= trunc_next;
            r_reg         <= r_next;
            j_reg         <= j_next;
            phase_reg     <= phase_next;
            last_reg      <= last_next;
            out_item_reg  <= out_item_next;
        end
    end

    // Every buffer read during an emit lies inside the stored message.
    a_read_in_message: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_READ |-> j_reg < POS_W'(n_reg))
        else $error("emit read beyond message length");

    // A waiting result only leaves the output register when it is taken.
    a_beat_not_lost: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid_reg) |-> $past(pop))
        else $error("result beat dropped without pop");

    // After the final beat of a message is loaded, the back returns to idle.
    a_last_ends_emit: assert property (@(posedge clk) disable iff (!rst_n)
        load && last_reg |=> state_reg == B_IDLE && out_item_reg.out_last)
        else $error("emit did not end on the last beat");

endmodule

`default_nettype wire

[src/rail_fence_transposition_core.sv]
// The emit is queued with a message's last byte; the idle back end pops it and reads RAM.
// Throughput in: one byte per cycle while the four-entry command queue has room.
// Output: a beat is read from the buffer RAM, then held until the output register is free.
// The idle back end writes the buffer one byte per cycle as it drains the queue.
// Reset (rst_n, async, active low) clears counts, flags and queues; rails_reg returns to 3.
`default_nettype none

module rail_fence_transposition_core #(
    parameter int BUFFER_DEPTH = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire rft_pkg::rails_t    cfg_wdata,
    input  wire logic               push,
    output logic                    full,
    input  wire rft_pkg::in_item_t  in_item,
    output logic                    empty,
    input  wire logic               pop,
    output rft_pkg::out_item_t      out_item
);
    import rft_pkg::*;

    cmd_t front_cmd;
    cmd_t queue_cmd;
    logic cmd_push;
    logic cmd_full;
    logic cmd_pop;
    logic cmd_empty;

    rft_front #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .push     (push),
        .full     (full),
        .in_item  (in_item),
        .cmd_push (cmd_push),
        .cmd      (front_cmd),
        .cmd_full (cmd_full)
    );

    rft_cmd_fifo u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (cmd_push),
        .wr_data(front_cmd),
        .full   (cmd_full),
        .rd_en  (cmd_pop),
        .rd_data(queue_cmd),
        .empty  (cmd_empty)
    );

    rft_emit #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (queue_cmd),
        .cmd_empty(cmd_empty),
        .cmd_pop  (cmd_pop),
        .empty    (empty),
        .pop      (pop),
        .out_item (out_item)
    );

endmodule

`default_nettype wire
